[src/kmst_pkg.sv]
// Package for the spanning-tree edge acceptor: widths, defaults, and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package kmst_pkg;

    localparam int NODES_DEF       = 1024;
    localparam int WEIGHT_BITS_DEF = 32;
    localparam int EP_W            = 10;
    localparam int W_IN            = 32;
    localparam int SUM_W           = 48;
    localparam int RANK_W          = 4;
    localparam int CNT_W           = 11;
    localparam logic [CNT_W-1:0]  CNT_RESET = 11'd1024;
    localparam logic [RANK_W-1:0] RANK_MAX  = 4'd15;

    typedef struct packed {
        logic ld_item;      // latch the input beat and its endpoint check
        logic start_a;      // begin a find at end_a
        logic start_b;      // begin a find at end_b
        logic par_rsel_walk;// parent read address: walk pointer, else cursor
        logic cur_adv;      // cursor steps to the parent just read
        logic comp_wr;      // point walk node at root, advance walk
        logic save_root_a;
        logic save_root_b;
        logic rank_rsel_b;  // rank read address: root b, else root a
        logic cap_rank_a;
        logic cap_rank_b;
        logic union_en;     // merge sets and add weight when roots differ
        logic clr_wr;       // write one entry of the clearing sweep
        logic out_ld;       // load the result registers
    } kmst_cmd_t;

    typedef struct packed {
        logic bad;          // latched endpoint check failed
        logic cur_is_root;  // parent just read equals the cursor
        logic walk_at_root; // compression walk reached the root
        logic clr_last;     // sweep is at the last entry
    } kmst_sts_t;

endpackage

[src/kruskal_mst_edge_acceptor_top.sv]
// Top level of the spanning-tree edge acceptor: controller plus datapath.
// Depends on kmst_pkg, kmst_ctrl, kmst_dp (which holds two kmst_ram).
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  input   | s_valid s_ready s_end_a s_end_b s_edge_weight  | in
//          | s_last_edge                                    |
//  result  | m_valid m_ready m_taken m_total_weight         | out
//          | m_bad_endpoint m_done_res                      |
//  config  | cfg_we cfg_wdata (node_count)                  | in
//
// One beat per edge. Each edge walks both endpoints to their roots and relinks
// the walked nodes by path compression, reads both ranks and merges roots that
// differ; a bad endpoint skips to the result. The parent store has one read port.
// Reset and every node_count write run a clearing sweep over all MAX_NODES
// entries (parent = own index, rank = 0) during which no beat is taken.
// A finished result waits in the output register while the next edge is
// accepted; only the hand-off of a second result stalls on m_ready.
`timescale 1ns / 1ps

module kruskal_mst_edge_acceptor_top
    import kmst_pkg::*;
#(
    parameter int MAX_NODES   = NODES_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [EP_W-1:0]  s_end_a,
    input  logic [EP_W-1:0]  s_end_b,
    input  logic [W_IN-1:0]  s_edge_weight,
    input  logic             s_last_edge,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_taken,
    output logic [SUM_W-1:0] m_total_weight,
    output logic             m_bad_endpoint,
    output logic             m_done_res
);

    kmst_cmd_t cmd;
    kmst_sts_t sts;

    // sequence the finds, compression and union
    kmst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_we  (cfg_we),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // hold the stores, roots, sum and result payload
    kmst_dp #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_end_a        (s_end_a),
        .s_end_b        (s_end_b),
        .s_edge_weight  (s_edge_weight),
        .s_last_edge    (s_last_edge),
        .m_taken        (m_taken),
        .m_total_weight (m_total_weight),
        .m_bad_endpoint (m_bad_endpoint),
        .m_done_res     (m_done_res)
    );

endmodule

[src/kmst_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used for the parent and rank stores; no dependencies.
`timescale 1ns / 1ps

module kmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/kmst_dp.sv]
// Datapath: parent and rank stores, find cursor and walk pointers, roots,
// saturating weight sum and result registers. Uses kmst_pkg and kmst_ram.
`timescale 1ns / 1ps

module kmst_dp
    import kmst_pkg::*;
#(
    parameter int MAX_NODES   = NODES_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  kmst_cmd_t          cmd,
    output kmst_sts_t          sts,
    input  logic               cfg_we,
    input  logic [CNT_W-1:0]   cfg_wdata,
    input  logic [EP_W-1:0]    s_end_a,
    input  logic [EP_W-1:0]    s_end_b,
    input  logic [W_IN-1:0]    s_edge_weight,
    input  logic               s_last_edge,
    output logic               m_taken,
    output logic [SUM_W-1:0]   m_total_weight,
    output logic               m_bad_endpoint,
    output logic               m_done_res
);

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam logic [NODE_W-1:0] LAST_IDX = NODE_W'(MAX_NODES - 1);
    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [SUM_W-1:0]  W_MASK   = SUM_W'((49'd1 << WEIGHT_BITS) - 49'd1);

    logic [CNT_W-1:0]  node_count_reg;
    logic [NODE_W-1:0] clr_idx_reg;
    logic [NODE_W-1:0] a_reg, b_reg, cur_reg, walk_reg, root_a_reg, root_b_reg;
    logic [SUM_W-1:0]  w_reg, sum_reg;
    logic              last_reg, bad_reg, taken_reg;
    logic [RANK_W-1:0] rank_a_reg, rank_b_reg;

    logic [31:0]       limit;
    logic              bad_in;
    logic [NODE_W-1:0] par_raddr, par_waddr, par_wdata, par_rdata;
    logic              par_we;
    logic [NODE_W-1:0] rank_raddr, rank_waddr;
    logic [RANK_W-1:0] rank_wdata, rank_rdata;
    logic              rank_we;
    logic              swap, do_inc;
    logic [NODE_W-1:0] child, top;
    logic [RANK_W-1:0] top_rank;
    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  sum_new;

    assign limit  = (32'(node_count_reg) > 32'(MAX_NODES)) ? 32'(MAX_NODES)
                                                            : 32'(node_count_reg);
    assign bad_in = (32'(s_end_a) >= limit) || (32'(s_end_b) >= limit);

    // union by rank: the lower-ranked root goes under the other; ties put a under b
    assign swap     = rank_a_reg > rank_b_reg;
    assign child    = swap ? root_b_reg : root_a_reg;
    assign top      = swap ? root_a_reg : root_b_reg;
    assign top_rank = swap ? rank_a_reg : rank_b_reg;
    assign do_inc   = (rank_a_reg == rank_b_reg) && (rank_b_reg < RANK_MAX);

    assign sum_wide = {1'b0, sum_reg} + {1'b0, w_reg};
    assign sum_new  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

    always_comb begin
        par_we    = 1'b0;
        par_waddr = clr_idx_reg;
        par_wdata = clr_idx_reg;
        rank_we   = 1'b0;
        rank_waddr = clr_idx_reg;
        rank_wdata = '0;
        if (cmd.clr_wr) begin
            par_we  = 1'b1;
            rank_we = 1'b1;
        end else if (cmd.comp_wr) begin
            par_we    = 1'b1;
            par_waddr = walk_reg;
            par_wdata = cur_reg;
        end else if (cmd.union_en && (root_a_reg != root_b_reg)) begin
            par_we     = 1'b1;
            par_waddr  = child;
            par_wdata  = top;
            rank_we    = do_inc;
            rank_waddr = top;
            rank_wdata = top_rank + RANK_W'(1);
        end
    end

    assign par_raddr  = cmd.par_rsel_walk ? walk_reg : cur_reg;
    assign rank_raddr = cmd.rank_rsel_b ? root_b_reg : root_a_reg;

    kmst_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_parent (
        .aclk (aclk), .we (par_we), .waddr (par_waddr), .wdata (par_wdata),
        .raddr (par_raddr), .rdata (par_rdata)
    );

    kmst_ram #(.WIDTH(RANK_W), .DEPTH(MAX_NODES)) u_rank (
        .aclk (aclk), .we (rank_we), .waddr (rank_waddr), .wdata (rank_wdata),
        .raddr (rank_raddr), .rdata (rank_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= CNT_RESET;
            clr_idx_reg    <= '0;
            sum_reg        <= '0;
        end else if (cfg_we) begin
            node_count_reg <= cfg_wdata;
            clr_idx_reg    <= '0;
            sum_reg        <= '0;
        end else begin
            if (cmd.clr_wr) begin
                clr_idx_reg <= clr_idx_reg + NODE_W'(1);
            end
            if (cmd.union_en && (root_a_reg != root_b_reg)) begin
                sum_reg <= sum_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_item) begin
            a_reg     <= NODE_W'(s_end_a);
            b_reg     <= NODE_W'(s_end_b);
            w_reg     <= SUM_W'(s_edge_weight) & W_MASK;
            last_reg  <= s_last_edge;
            bad_reg   <= bad_in;
            taken_reg <= 1'b0;
        end else if (cmd.union_en) begin
            taken_reg <= root_a_reg != root_b_reg;
        end
        if (cmd.start_a) begin
            cur_reg  <= a_reg;
            walk_reg <= a_reg;
        end else if (cmd.start_b) begin
            cur_reg  <= b_reg;
            walk_reg <= b_reg;
        end else begin
            if (cmd.cur_adv) begin
                cur_reg <= par_rdata;
            end
            if (cmd.comp_wr) begin
                walk_reg <= par_rdata;
            end
        end
        if (cmd.save_root_a) begin
            root_a_reg <= cur_reg;
        end
        if (cmd.save_root_b) begin
            root_b_reg <= cur_reg;
        end
        if (cmd.cap_rank_a) begin
            rank_a_reg <= rank_rdata;
        end
        if (cmd.cap_rank_b) begin
            rank_b_reg <= rank_rdata;
        end
        if (cmd.out_ld) begin
            m_taken        <= taken_reg;
            m_total_weight <= sum_reg;
            m_bad_endpoint <= bad_reg;
            m_done_res     <= last_reg;
        end
    end

    assign sts.bad          = bad_reg;
    assign sts.cur_is_root  = par_rdata == cur_reg;
    assign sts.walk_at_root = walk_reg == cur_reg;
    assign sts.clr_last     = clr_idx_reg == LAST_IDX;

endmodule

[src/kmst_ctrl.sv]
// Controller: sequences clearing sweep, two finds with path compression,
// rank reads, union and result hand-off. Uses kmst_pkg.
`timescale 1ns / 1ps

module kmst_ctrl
    import kmst_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_we,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  kmst_sts_t sts,
    output kmst_cmd_t cmd
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_START = 4'd2;
    localparam logic [3:0] S_FRD   = 4'd3;
    localparam logic [3:0] S_FCHK  = 4'd4;
    localparam logic [3:0] S_CRD   = 4'd5;
    localparam logic [3:0] S_CWR   = 4'd6;
    localparam logic [3:0] S_RKA   = 4'd7;
    localparam logic [3:0] S_RKB   = 4'd8;
    localparam logic [3:0] S_RKW   = 4'd9;
    localparam logic [3:0] S_UNION = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       side_reg, side_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE) && !cfg_we;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        side_next    = side_reg;
        cmd          = '0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.ld_item = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START: begin
                if (sts.bad) begin
                    state_next = S_OUT;
                end else begin
                    cmd.start_a = 1'b1;
                    side_next   = 1'b0;
                    state_next  = S_FRD;
                end
            end
            S_FRD: begin
                state_next = S_FCHK;
            end
            S_FCHK: begin
                if (sts.cur_is_root) begin
                    state_next = S_CRD;
                end else begin
                    cmd.cur_adv = 1'b1;
                    state_next  = S_FRD;
                end
            end
            S_CRD: begin
                cmd.par_rsel_walk = 1'b1;
                if (!sts.walk_at_root) begin
                    state_next = S_CWR;
                end else if (!side_reg) begin
                    cmd.save_root_a = 1'b1;
                    cmd.start_b     = 1'b1;
                    side_next       = 1'b1;
                    state_next      = S_FRD;
                end else begin
                    cmd.save_root_b = 1'b1;
                    state_next      = S_RKA;
                end
            end
            S_CWR: begin
                cmd.comp_wr = 1'b1;
                state_next  = S_CRD;
            end
            S_RKA: begin
                state_next = S_RKB;
            end
            S_RKB: begin
                cmd.rank_rsel_b = 1'b1;
                cmd.cap_rank_a  = 1'b1;
                state_next      = S_RKW;
            end
            S_RKW: begin
                cmd.cap_rank_b = 1'b1;
                state_next     = S_UNION;
            end
            S_UNION: begin
                cmd.union_en = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (cfg_we) begin
            cmd        = '0;
            state_next = S_CLEAR;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_ld) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            side_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            side_reg    <= side_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_ld |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before it was taken");

    a_cfg_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> (state_reg == S_CLEAR))
        else $error("register write did not start the clearing sweep");

    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_ready)
        else $error("input taken during clearing sweep");

endmodule

[tb/kmst_checker.sv]
// Checker for the spanning-tree edge acceptor: watches the edge and result
// channels, predicts each result with its own union-find copy, and compares.
// Depends on kmst_pkg.
`timescale 1ns / 1ps

module kmst_checker
    import kmst_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic [EP_W-1:0]  s_end_a,
    input  logic [EP_W-1:0]  s_end_b,
    input  logic [W_IN-1:0]  s_edge_weight,
    input  logic             s_last_edge,
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic             m_taken,
    input  logic [SUM_W-1:0] m_total_weight,
    input  logic             m_bad_endpoint,
    input  logic             m_done_res,
    output int               fail_count,
    output int               pending_results,
    output int               taken_count,
    output int               bad_count
);

    typedef struct packed {
        logic             taken;
        logic [SUM_W-1:0] total;
        logic             bad;
        logic             done;
    } edge_result_t;

    localparam logic [SUM_W-1:0] SUM_SAT = {SUM_W{1'b1}};

    logic [EP_W-1:0]   forest_parent [NODES_DEF];
    logic [RANK_W-1:0] forest_rank [NODES_DEF];
    logic [SUM_W-1:0]  tree_weight;
    logic [CNT_W-1:0]  vertex_limit;
    edge_result_t      expected_results[$];

    function automatic void clear_forest();
        for (int i = 0; i < NODES_DEF; i++) begin
            forest_parent[i] = EP_W'(i);
            forest_rank[i] = '0;
        end
        tree_weight = '0;
    endfunction

    function automatic logic [EP_W-1:0] root_of(logic [EP_W-1:0] v);
        logic [EP_W-1:0] r;
        logic [EP_W-1:0] nxt;
        r = v;
        while (forest_parent[r] != r) r = forest_parent[r];
        while (v != r) begin
            nxt = forest_parent[v];
            forest_parent[v] = r;
            v = nxt;
        end
        return r;
    endfunction

    function automatic edge_result_t join_edge(logic [EP_W-1:0] a, logic [EP_W-1:0] b,
                                               logic [W_IN-1:0] w, logic last);
        edge_result_t res;
        logic [EP_W-1:0] ra;
        logic [EP_W-1:0] rb;
        logic [EP_W-1:0] t;
        logic [CNT_W-1:0] lim;
        lim = (vertex_limit > CNT_W'(NODES_DEF)) ? CNT_W'(NODES_DEF) : vertex_limit;
        res = '0;
        res.done = last;
        if ({1'b0, a} >= lim || {1'b0, b} >= lim) begin
            res.bad = 1'b1;
        end else begin
            ra = root_of(a);
            rb = root_of(b);
            if (ra != rb) begin
                if (forest_rank[ra] > forest_rank[rb]) begin
                    t = ra; ra = rb; rb = t;
                end
                if (forest_rank[ra] == forest_rank[rb] && forest_rank[rb] < RANK_MAX)
                    forest_rank[rb]++;
                forest_parent[ra] = rb;
                res.taken = 1'b1;
                if ({16'b0, w} > SUM_SAT - tree_weight) tree_weight = SUM_SAT;
                else tree_weight = tree_weight + {16'b0, w};
            end
        end
        res.total = tree_weight;
        return res;
    endfunction

    always @(posedge aclk) begin
        edge_result_t got;
        edge_result_t exp_r;
        if (!aresetn) begin
            vertex_limit <= CNT_RESET;
            clear_forest();
            expected_results.delete();
            fail_count <= 0;
            taken_count <= 0;
            bad_count <= 0;
        end else begin
            if (cfg_we) begin
                vertex_limit <= cfg_wdata;
                clear_forest();
            end
            if (m_valid && m_ready) begin
                got = '{m_taken, m_total_weight, m_bad_endpoint, m_done_res};
                if (expected_results.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result beat: %p", got);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        if (fail_count < 10)
                            $display("mismatch: expected %p, got %p", exp_r, got);
                        fail_count <= fail_count + 1;
                    end
                    taken_count <= taken_count + got.taken;
                    bad_count <= bad_count + got.bad;
                end
            end
            // predict after the pop so a same-edge result is never compared early
            if (s_valid && s_ready)
                expected_results.insert(expected_results.size(),
                                        join_edge(s_end_a, s_end_b, s_edge_weight,
                                                  s_last_edge));
        end
    end

    assign pending_results = expected_results.size();

endmodule

[tb/testbench.sv]
// Top of the edge acceptor testbench: clock, reset, edge stimulus, result
// stall pattern and verdict. Depends on kmst_pkg, kmst_checker and the RTL.
`timescale 1ns / 1ps

module testbench;
    import kmst_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_we = 1'b0;
    logic [CNT_W-1:0] cfg_wdata = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [EP_W-1:0]  s_end_a = '0;
    logic [EP_W-1:0]  s_end_b = '0;
    logic [W_IN-1:0]  s_edge_weight = '0;
    logic             s_last_edge = 1'b0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic             m_taken;
    logic [SUM_W-1:0] m_total_weight;
    logic             m_bad_endpoint;
    logic             m_done_res;

    int  fail_count;
    int  pending_results;
    int  taken_count;
    int  bad_count;
    int  cycle_count = 0;
    int  edges_sent = 0;
    int  graphs_run = 0;
    bit  steady_phase = 1'b0;   // no idling on either side while set
    logic [CNT_W-1:0] vertices = CNT_RESET;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    kruskal_mst_edge_acceptor_top DUT (
        .aclk, .aresetn, .cfg_we, .cfg_wdata,
        .s_valid, .s_ready, .s_end_a, .s_end_b, .s_edge_weight, .s_last_edge,
        .m_valid, .m_ready, .m_taken, .m_total_weight, .m_bad_endpoint, .m_done_res
    );

    kmst_checker u_checker (
        .aclk, .aresetn, .cfg_we, .cfg_wdata,
        .s_valid, .s_ready, .s_end_a, .s_end_b, .s_edge_weight, .s_last_edge,
        .m_valid, .m_ready, .m_taken, .m_total_weight, .m_bad_endpoint, .m_done_res,
        .fail_count, .pending_results, .taken_count, .bad_count
    );

    // Stall the result side about 32 percent of the time, except in the steady phase.
    always @(posedge aclk) begin
        m_ready <= steady_phase || ($urandom_range(99) >= 32);
    end

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Present one edge beat and hold it until the block takes it. Valid stays
    // up after the beat; idle cycles and the callers drop it.
    task automatic send_edge(input logic [EP_W-1:0] a, input logic [EP_W-1:0] b,
                             input logic [W_IN-1:0] w, input logic last);
        if (!steady_phase) begin
            while ($urandom_range(99) < 32) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_end_a <= a;
        s_end_b <= b;
        s_edge_weight <= w;
        s_last_edge <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        edges_sent++;
    endtask

    // Wait for every result, let the block go idle, then load a new node count.
    // The write also starts the clearing sweep, which s_ready covers.
    task automatic drain_and_write(input logic [CNT_W-1:0] count);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= count;
        @(posedge aclk);
        cfg_we <= 1'b0;
        vertices = count;
        graphs_run++;
    endtask

    // Random vertex, mostly in range; a few beyond the count when possible.
    function automatic logic [EP_W-1:0] pick_vertex();
        int lim;
        lim = (vertices > NODES_DEF) ? NODES_DEF : int'(vertices);
        if (lim == 0 || $urandom_range(99) < 4) return EP_W'($urandom);
        return EP_W'($urandom_range(lim - 1));
    endfunction

    // One graph: random edges with mostly nondecreasing weights, a few random, last edge marked.
    task automatic run_graph(input int n_edges, input int wmax_shift);
        logic [W_IN-1:0] w;
        logic [W_IN-1:0] step;
        w = '0;
        for (int i = 0; i < n_edges; i++) begin
            step = W_IN'($urandom) >> wmax_shift;
            w = (w > ~step) ? '1 : w + step;
            send_edge(pick_vertex(), pick_vertex(), ($urandom_range(99) < 5) ? $urandom : w,
                      i == n_edges - 1);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes at reset count, then small graph specials.
        send_edge(10'd0, 10'd1023, 32'hFFFF_FFFF, 1'b0);
        send_edge(10'd1023, 10'd0, 32'hFFFF_FFFF, 1'b0);   // same set now
        send_edge(10'd5, 10'd5, 32'd7, 1'b0);               // self loop
        send_edge(10'h155, 10'h2AA, 32'h5555_5555, 1'b0);
        send_edge(10'h2AA, 10'h155, 32'hAAAA_AAAA, 1'b1);
        drain_and_write(11'd0);                             // every edge bad
        send_edge(10'd0, 10'd0, 32'd1, 1'b1);
        drain_and_write(11'd4);
        send_edge(10'd3, 10'd4, 32'd1, 1'b0);               // b out of range
        send_edge(10'd4, 10'd0, 32'd1, 1'b0);               // a out of range
        send_edge(10'd0, 10'd1, 32'd2, 1'b0);               // equal ranks
        send_edge(10'd2, 10'd3, 32'd3, 1'b0);
        send_edge(10'd1, 10'd3, 32'd4, 1'b0);
        send_edge(10'd0, 10'd2, 32'd5, 1'b1);               // compression only
        drain_and_write(11'd2047);                          // limited to 1024
        send_edge(10'd1023, 10'd1022, 32'd9, 1'b1);
        // Saturating the sum would take ~65537 max-weight edges, too long to send; the
        // deep tree below adds max weights without reaching the top.
        drain_and_write(11'd1024);
        // Deep ranks: build a binomial tree over 64 nodes by merging pairs.
        for (int s = 1; s < 64; s = s * 2)
            for (int i = 0; i < 64; i += 2 * s)
                send_edge(EP_W'(i), EP_W'(i + s), 32'hFFFF_FFFF, 1'b0);

        // Pause until every result is back before the random part.
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);

        // Random graphs over several node counts; one no-idle stretch.
        for (int g = 0; g < 40; g++) begin
            steady_phase = (g >= 10 && g < 14);
            case (g % 5)
                0: drain_and_write(11'd1);
                1: drain_and_write(CNT_W'($urandom_range(2, 16)));
                2: drain_and_write(CNT_W'($urandom_range(17, 200)));
                3: drain_and_write(11'd1024);
                default: drain_and_write(CNT_W'($urandom_range(1025, 2047)));
            endcase
            run_graph($urandom_range(25, 55), $urandom_range(8, 31));
        end
        steady_phase = 1'b0;

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
        $display("%0d edges over %0d node-count settings: %0d taken, %0d out of range",
                 edges_sent, graphs_run, taken_count, bad_count);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
